/* rtl/fq_pkg.sv */
// Shared types, constants and float decode helpers for the float-to-int quantizer.
`default_nettype none
package fq_pkg;

  // Register indexes on the configuration port.
  localparam logic REG_SCALE = 1'b0;
  localparam logic REG_MODE  = 1'b1;

  localparam int unsigned DIV_BITS       = 26;
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES     = DIV_BITS / BITS_PER_STAGE;

  // Saturation limits as magnitudes.
  localparam logic [16:0] LIM_I8_POS  = 17'd127;
  localparam logic [16:0] LIM_I8_NEG  = 17'd128;
  localparam logic [16:0] LIM_I16_POS = 17'd32767;
  localparam logic [16:0] LIM_I16_NEG = 17'd32768;

  typedef enum logic [1:0] {
    KIND_NUM,
    KIND_ZERO,
    KIND_SAT
  } kind_t;

  typedef struct packed {
    logic              sign;
    logic              nan;
    logic              inf;
    logic              zero;
    logic [23:0]       man;
    logic signed [9:0] exp;
  } fp_dec_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    kind_t             kind;
    logic              sign;
    logic signed [9:0] exp;
    logic [24:0]       rem;
    logic [25:0]       q;
  } div_t;

  // Leading zeros of a 24-bit word; returns 0 for a zero word.
  function automatic logic [4:0] lzc24(input logic [23:0] x);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (x[i]) begin
        n = 5'(23 - i);
      end
    end
    return n;
  endfunction

  // Splits a float32 pattern and normalizes nonzero subnormals so man[23] is set.
  function automatic fp_dec_t fp_decode(input logic [31:0] b);
    fp_dec_t    d;
    logic [7:0] e;
    logic [22:0] f;
    logic [4:0] lz;
    e = b[30:23];
    f = b[22:0];
    lz = lzc24({1'b0, f});
    d.sign = b[31];
    d.nan  = (e == 8'hFF) && (f != 23'd0);
    d.inf  = (e == 8'hFF) && (f == 23'd0);
    d.zero = (e == 8'h00) && (f == 23'd0);
    if (e == 8'h00) begin
      d.man = {1'b0, f} << lz;
      d.exp = $signed(10'(-126)) - $signed({5'b0, lz});
    end else begin
      d.man = {1'b1, f};
      d.exp = $signed({2'b0, e}) - 10'sd127;
    end
    return d;
  endfunction

endpackage
`default_nettype wire

/* rtl/fq_if.sv */
// Valid/ready stream interfaces for the quantizer input and result channels.
`default_nettype none
interface fq_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_bits;
  logic        in_last;
  modport source (output valid, output value_bits, output in_last, input ready);
  modport sink (input valid, input value_bits, input in_last, output ready);
endinterface

interface fq_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quantized;
  logic               out_last;
  modport source (output valid, output quantized, output out_last, input ready);
  modport sink (input valid, input quantized, input out_last, output ready);
endinterface
`default_nettype wire

/* rtl/float32_to_int_quantizer_core.sv */
// Pipelined single-precision divide, round and saturate to int8 or int16.
//
// Usage: each transfer on in_ch carries one float32 element and a last mark.
// The element is divided by the scale register, rounded to nearest-even in
// single precision, then rounded to an integer with ties away from zero and
// saturated to int8 (out_mode 0) or int16 (out_mode 1). NaN results give 0.
// One transfer on out_ch follows per input, in order, with the last mark.
// The mantissa divider is a restoring array of 13 register stages retiring
// two quotient bits each, which lets one element enter every cycle.
// When out_ch stalls with a result waiting, the whole pipeline holds and
// in_ch.ready drops; nothing is lost or repeated.
// Registers: scale at byte address 0 (reset 1.0), out_mode at address 4
// (reset 0). Write them only while no element is in flight.
// Reset (rst, synchronous) empties the pipeline and restores the registers.
`default_nettype none
module float32_to_int_quantizer_core
  import fq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  fq_in_if.sink            in_ch,
  fq_out_if.source         out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0] scale_bits;
  logic        out_mode;
  logic        adv;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_bits <= 32'h3F80_0000;
      out_mode   <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_SCALE: scale_bits <= pwdata;
        REG_MODE:  out_mode   <= pwdata[0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SCALE: prdata = scale_bits;
      REG_MODE:  prdata = {31'd0, out_mode};
      default:   prdata = 32'd0;
    endcase
  end

  // Decoded scale; the user must keep it stable while items are in flight.
  fp_dec_t sc;
  always_ff @(posedge clk) begin
    sc <= fp_decode(scale_bits);
  end

  logic out_valid;
  assign adv         = !out_valid || out_ch.ready;
  assign in_ch.ready = adv;

  // Input register.
  logic        a_valid;
  logic        a_last;
  logic [31:0] a_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_ch.valid;
    end
    if (adv) begin
      a_value <= in_ch.value_bits;
      a_last  <= in_ch.in_last;
    end
  end

  // Classification and divider setup.
  fp_dec_t va;
  div_t    div_in;

  always_comb begin
    va = fp_decode(a_value);
    div_in.valid = a_valid;
    div_in.last  = a_last;
    div_in.sign  = va.sign ^ sc.sign;
    div_in.exp   = va.exp - sc.exp;
    div_in.rem   = {1'b0, va.man};
    div_in.q     = '0;
    if (va.nan || sc.nan) begin
      div_in.kind = KIND_ZERO;
    end else if (sc.zero) begin
      div_in.kind = va.zero ? KIND_ZERO : KIND_SAT;
    end else if (va.inf) begin
      div_in.kind = sc.inf ? KIND_ZERO : KIND_SAT;
    end else if (sc.inf || va.zero) begin
      div_in.kind = KIND_ZERO;
    end else begin
      div_in.kind = KIND_NUM;
    end
  end

  // Restoring divider: stage k holds the state after 2*k quotient bits.
  div_t dv [DIV_STAGES+1];
  div_t dv_next [DIV_STAGES];

  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      dv_next[k] = dv[k];
      for (int j = 0; j < BITS_PER_STAGE; j++) begin
        if (dv_next[k].rem >= {1'b0, sc.man}) begin
          dv_next[k].q   = {dv_next[k].q[24:0], 1'b1};
          dv_next[k].rem = {dv_next[k].rem[23:0] - sc.man, 1'b0};
        end else begin
          dv_next[k].q   = {dv_next[k].q[24:0], 1'b0};
          dv_next[k].rem = {dv_next[k].rem[23:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
        dv[k].valid <= 1'b0;
      end
    end else if (adv) begin
      dv[0] <= div_in;
      for (int k = 0; k < DIV_STAGES; k++) begin
        dv[k+1] <= dv_next[k];
      end
    end
  end

  // Round the quotient to single precision.
  div_t              d_fin;
  logic [23:0]       rm;
  logic              rg;
  logic              rs;
  logic              rnd;
  logic [24:0]       rsum;
  logic signed [9:0] rexp;
  logic [23:0]       r_man_next;
  logic signed [9:0] r_exp_next;

  always_comb begin
    d_fin = dv[DIV_STAGES];
    if (d_fin.q[25]) begin
      rm   = d_fin.q[25:2];
      rg   = d_fin.q[1];
      rs   = d_fin.q[0] || (d_fin.rem != 25'd0);
      rexp = d_fin.exp;
    end else begin
      rm   = d_fin.q[24:1];
      rg   = d_fin.q[0];
      rs   = d_fin.rem != 25'd0;
      rexp = d_fin.exp - 10'sd1;
    end
    rnd  = rg && (rs || rm[0]);
    rsum = {1'b0, rm} + {24'd0, rnd};
    if (rsum[24]) begin
      r_man_next = rsum[24:1];
      r_exp_next = rexp + 10'sd1;
    end else begin
      r_man_next = rsum[23:0];
      r_exp_next = rexp;
    end
  end

  logic              r_valid;
  logic              r_last;
  kind_t             r_kind;
  logic              r_sign;
  logic [23:0]       r_man;
  logic signed [9:0] r_exp;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (adv) begin
      r_valid <= d_fin.valid;
    end
    if (adv) begin
      r_last <= d_fin.last;
      r_kind <= d_fin.kind;
      r_sign <= d_fin.sign;
      r_man  <= r_man_next;
      r_exp  <= r_exp_next;
    end
  end

  // Integer rounding with ties away from zero, then saturation.
  logic [4:0]  sh;
  logic [4:0]  hb;
  logic [16:0] mag;
  logic [16:0] lim;
  logic        sat;
  logic [15:0] q_next;

  always_comb begin
    sh  = 5'(10'sd23 - r_exp);
    hb  = 5'(sh - 5'd1);
    mag = 17'd0;
    sat = 1'b0;
    case (r_kind)
      KIND_SAT: sat = 1'b1;
      KIND_NUM: begin
        if (r_exp > 10'sd15) begin
          sat = 1'b1;
        end else if (r_exp >= -10'sd1) begin
          mag = 17'(r_man >> sh) + {16'd0, r_man[hb]};
        end
      end
      default: ;
    endcase
    if (out_mode) begin
      lim = r_sign ? LIM_I16_NEG : LIM_I16_POS;
    end else begin
      lim = r_sign ? LIM_I8_NEG : LIM_I8_POS;
    end
    if (sat || (mag > lim)) begin
      mag = lim;
    end
    q_next = r_sign ? 16'(-mag) : mag[15:0];
  end

  logic [15:0] q_reg;
  logic        last_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= r_valid;
    end
    if (adv) begin
      q_reg    <= q_next;
      last_reg <= r_last;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.quantized = q_reg;
  assign out_ch.out_last  = last_reg;

endmodule
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the float32 to int8/int16 quantizer core.
`timescale 1ns / 100ps
module tb_top;
  import fq_pkg::*;

  localparam int CYCLE_LIMIT = 2000;

  typedef struct {
    logic        sgn;
    logic        is_nan;
    logic        is_inf;
    logic        is_zero;
    logic [23:0] mant;
    int          ex;
  } fp_parts_t;

  typedef struct {
    logic signed [15:0] q;
    logic               last;
  } quant_t;

  typedef struct {
    logic [31:0]        value;
    logic               last;
    logic               typed;
    logic signed [15:0] q;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic pready;

  fq_in_if  in_if();
  fq_out_if out_if();

  float32_to_int_quantizer_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [31:0] cur_scale = 32'h3F80_0000;
  logic        cur_mode = 1'b0;
  logic        calm = 1'b0;
  int          errors = 0;
  int          idle_cycles = 0;
  quant_t      pending_q[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.value_bits = 32'd0;
    in_if.in_last = 1'b0;
    out_if.ready = 1'b0;
  end

  function automatic fp_parts_t split_float(logic [31:0] b);
    fp_parts_t p;
    p.sgn     = b[31];
    p.is_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    p.is_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    p.is_zero = (b[30:0] == 31'd0);
    if (b[30:23] == 8'd0) begin
      p.mant = {1'b0, b[22:0]};
      p.ex = -126;
      if (!p.is_zero) begin
        while (!p.mant[23]) begin
          p.mant = p.mant << 1;
          p.ex--;
        end
      end
    end else begin
      p.mant = {1'b1, b[22:0]};
      p.ex = int'(b[30:23]) - 127;
    end
    return p;
  endfunction

  // Divides in single precision with round to nearest even, then rounds to an
  // integer with ties away from zero and saturates to the selected width.
  function automatic logic signed [15:0] quantize(logic [31:0] v, logic [31:0] s,
                                                  logic mode);
    fp_parts_t a;
    fp_parts_t b;
    logic neg;
    int hi, lo, d, e, r;
    longint unsigned num, qt, rem, sig, fx, t;
    logic rb, st;
    a = split_float(v);
    b = split_float(s);
    hi = mode ? 32767 : 127;
    lo = mode ? -32768 : -128;
    neg = a.sgn ^ b.sgn;
    if (a.is_nan || b.is_nan) return 16'sd0;
    if (b.is_zero) return a.is_zero ? 16'sd0 : 16'(neg ? lo : hi);
    if (a.is_inf) return b.is_inf ? 16'sd0 : 16'(neg ? lo : hi);
    if (b.is_inf || a.is_zero) return 16'sd0;
    d = a.ex - b.ex;
    // Below a quarter the rounded quotient can never reach one half.
    if (d < -3) return 16'sd0;
    if (d >= 17) return 16'(neg ? lo : hi);
    num = longint'(a.mant) << 25;
    qt = num / b.mant;
    rem = num % b.mant;
    if (qt[25]) begin
      sig = qt >> 2;
      rb = qt[1];
      st = qt[0] | (rem != 0);
      e = d;
    end else begin
      sig = qt >> 1;
      rb = qt[0];
      st = (rem != 0);
      e = d - 1;
    end
    sig = sig & 64'hFF_FFFF;
    if (rb && (st || sig[0])) sig++;
    if (sig == 64'h100_0000) begin
      sig = 64'h80_0000;
      e++;
    end
    if (e >= 16) return 16'(neg ? lo : hi);
    // Fixed point with 31 fraction bits; adding one half rounds ties away.
    fx = sig << (e + 8);
    t = (fx + (64'd1 << 30)) >> 31;
    r = neg ? -int'(t) : int'(t);
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return 16'(r);
  endfunction

  task automatic reg_write(logic idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_SCALE) cur_scale = data;
    else cur_mode = data[0];
    @(posedge clk);
  endtask

  task automatic send_element(logic [31:0] v, logic last, logic typed,
                              logic signed [15:0] q);
    int w;
    quant_t x;
    w = calm ? 0 : $urandom_range(0, 18);
    if (w > 0) begin
      in_if.valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.value_bits <= v;
    in_if.in_last <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    x.q = typed ? q : quantize(v, cur_scale, cur_mode);
    x.last = last;
    pending_q.push_back(x);
  endtask

  task automatic drain_pipe();
    in_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] random_element(logic [31:0] s);
    logic [31:0] v;
    int se, ex;
    v = $urandom;
    case ($urandom_range(0, 9))
      0, 1: ;
      2: begin
        case ($urandom_range(0, 4))
          0: v = {v[31], 31'd0};
          1: v = {v[31], 8'hFF, 23'd0};
          2: v = {v[31], 8'hFF, v[22:0] | 23'd1};
          3: v = {v[31], 8'h00, v[22:0]};
          default: v = {v[31], 8'hFE, v[22:0]};
        endcase
      end
      default: begin
        se = (s[30:23] == 8'd0 || s[30:23] == 8'hFF) ? 127 : int'(s[30:23]);
        ex = se + $urandom_range(0, 24) - 6;
        if (ex < 1) ex = 1;
        if (ex > 254) ex = 254;
        v[30:23] = 8'(ex);
        // Clearing low fraction bits lands many quotients on exact halves.
        if ($urandom_range(0, 2) == 0) v[15:0] = 16'd0;
      end
    endcase
    return v;
  endfunction

  initial begin
    int w;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      w = calm ? 0 : $urandom_range(0, 18);
      if (w > 0) begin
        out_if.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    quant_t x;
    if (!rst && out_if.valid && out_if.ready) begin
      if (pending_q.size() == 0) begin
        $error("quantized: result with no expectation, actual %0d", out_if.quantized);
        errors++;
      end else begin
        x = pending_q.pop_front();
        if (out_if.quantized !== x.q) begin
          $error("quantized: expected %0d, actual %0d", x.q, out_if.quantized);
          errors++;
        end
        if (out_if.out_last !== x.last) begin
          $error("out_last: expected %0d, actual %0d", x.last, out_if.out_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    logic [31:0] scales[$];
    logic        modes[$];
    logic [31:0] s;
    // Reset settings: scale 1.0, int8 saturation.
    rows = '{
      '{32'h0000_0000, 1'b0, 1'b1, 16'sd0},
      '{32'h8000_0000, 1'b1, 1'b1, 16'sd0},
      '{32'h4020_0000, 1'b0, 1'b1, 16'sd3},
      '{32'hC020_0000, 1'b1, 1'b1, -16'sd3},
      '{32'h3FC0_0000, 1'b0, 1'b1, 16'sd2},
      '{32'h3F00_0000, 1'b0, 1'b1, 16'sd1},
      '{32'hBF00_0000, 1'b0, 1'b1, -16'sd1},
      '{32'h3EFF_FFFF, 1'b1, 1'b1, 16'sd0},
      '{32'h42FF_0000, 1'b0, 1'b1, 16'sd127},
      '{32'hC301_0000, 1'b0, 1'b1, -16'sd128},
      '{32'h447A_0000, 1'b0, 1'b1, 16'sd127},
      '{32'hC47A_0000, 1'b0, 1'b1, -16'sd128},
      '{32'h7F80_0000, 1'b1, 1'b1, 16'sd127},
      '{32'hFF80_0000, 1'b0, 1'b1, -16'sd128},
      '{32'h7FC0_0000, 1'b0, 1'b1, 16'sd0},
      '{32'hFF80_0001, 1'b1, 1'b1, 16'sd0},
      '{32'h7F7F_FFFF, 1'b0, 1'b1, 16'sd127},
      '{32'hFF7F_FFFF, 1'b0, 1'b1, -16'sd128},
      '{32'h0000_0001, 1'b1, 1'b1, 16'sd0},
      '{32'h807F_FFFF, 1'b0, 1'b1, 16'sd0},
      '{32'hFFFF_FFFF, 1'b1, 1'b1, 16'sd0},
      '{32'h4B7F_FFFF, 1'b0, 1'b0, 16'sd0},
      '{32'h3F7F_FFFF, 1'b0, 1'b0, 16'sd0}
    };
    scales = '{32'h3F80_0000, 32'h3C00_0000, 32'h0000_0000, 32'h8000_0000,
               32'h7F80_0000, 32'h7FC0_0000, 32'h0000_0001, 32'h7F7F_FFFF,
               32'hBF80_0000, 32'h3F00_0000, 32'hFFFF_FFFF, 32'h3A80_0000,
               32'h0, 32'h0, 32'h0};
    modes = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0,
              1'b1, 1'b0, 1'b1, 1'b1};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) send_element(rows[i].value, rows[i].last, rows[i].typed, rows[i].q);
    drain_pipe();
    // Int16 extremes under scale 1.0.
    reg_write(REG_MODE, 32'd1);
    send_element(32'h46FF_FE00, 1'b0, 1'b1, 16'sd32767);
    send_element(32'hC700_0000, 1'b1, 1'b1, -16'sd32768);
    send_element(32'h4780_0000, 1'b0, 1'b1, 16'sd32767);
    send_element(32'hC780_0000, 1'b0, 1'b1, -16'sd32768);
    foreach (scales[p]) begin
      drain_pipe();
      s = scales[p];
      if (p >= 12) begin
        s = $urandom;
        if (p == 13) s[30:23] = 8'(int'($urandom_range(110, 140)));
      end
      reg_write(REG_SCALE, s);
      reg_write(REG_MODE, {31'd0, modes[p]});
      calm = (p % 4 == 3);
      for (int k = 0; k < 60; k++) begin
        // Now and then let the pipe run dry before the next element.
        if (($urandom_range(0, 40) == 0) && (pending_q.size() != 0)) begin
          in_if.valid <= 1'b0;
          while (pending_q.size() != 0) @(posedge clk);
        end
        send_element(random_element(s), 1'($urandom), 1'b0, 16'sd0);
      end
    end
    in_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
